// File: rtl/assert_macros.svh
// Assertion macros included by the spq_datapath module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define SPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define SPQ_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// File: rtl/spq_pkg.sv
package spq_pkg;

   localparam int PRI_W  = 4;
   localparam int PAY_W  = 16;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   localparam logic [STAT_W-1:0] STATUS_INSERTED = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_REMOVED  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd3;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_REMOVE = 1'b1;

   // Operation that the controller orders from the datapath.
   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_INSERT = 3'd1,
      OP_REMOVE = 3'd2,
      OP_FULL   = 3'd3,
      OP_EMPTY  = 3'd4
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } stat_type;

endpackage

// File: rtl/spq_ctrl.sv
module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  spq_pkg::stat_type stat,
   output spq_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_HOLD = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // A new request may enter while the held result is being taken.
   assign req_ready = !reset && ((state_ff == S_IDLE) || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_HOLD);

   always_comb begin
      cmd.op = spq_pkg::OP_NONE;
      if (accept) begin
         if (req_action == spq_pkg::ACTION_INSERT) begin
            cmd.op = stat.full ? spq_pkg::OP_FULL : spq_pkg::OP_INSERT;
         end else begin
            cmd.op = stat.empty ? spq_pkg::OP_EMPTY : spq_pkg::OP_REMOVE;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_HOLD;
         end
         S_HOLD: begin
            if (accept) state_in = S_HOLD;
            else if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/spq_datapath.sv
`include "assert_macros.svh"

module spq_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  spq_pkg::cmd_type            cmd,
   input  logic [spq_pkg::PRI_W-1:0]   new_pri,
   input  logic [spq_pkg::PAY_W-1:0]   new_pay,
   output spq_pkg::stat_type           stat,
   output logic [spq_pkg::STAT_W-1:0]  rsp_status,
   output logic [spq_pkg::PAY_W-1:0]   rsp_payload,
   output logic [spq_pkg::PRI_W-1:0]   rsp_priority,
   output logic [spq_pkg::OCC_W-1:0]   rsp_occupancy
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [spq_pkg::PRI_W-1:0]  cell_pri_ff [DEPTH];
   logic [spq_pkg::PRI_W-1:0]  cell_pri_in [DEPTH];
   logic [spq_pkg::PAY_W-1:0]  cell_pay_ff [DEPTH];
   logic [spq_pkg::PAY_W-1:0]  cell_pay_in [DEPTH];
   logic [CW-1:0]              count_ff;
   logic [CW-1:0]              count_in;
   logic [DEPTH-1:0]           stay;
   logic [spq_pkg::STAT_W-1:0] status_ff;
   logic [spq_pkg::PAY_W-1:0]  out_pay_ff;
   logic [spq_pkg::PRI_W-1:0]  out_pri_ff;
   logic [spq_pkg::OCC_W-1:0]  occ_ff;

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);

   // Each held cell of greater or equal priority keeps its place on an insert.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         stay[i] = (CW'(i) < count_ff) && (cell_pri_ff[i] >= new_pri);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_pri_in[i] = cell_pri_ff[i];
         cell_pay_in[i] = cell_pay_ff[i];
      end
      count_in = count_ff;
      case (cmd.op)
         spq_pkg::OP_INSERT: begin
            if (!stay[0]) begin
               cell_pri_in[0] = new_pri;
               cell_pay_in[0] = new_pay;
            end
            for (int i = 1; i < DEPTH; i++) begin
               if (!stay[i]) begin
                  if (stay[i-1]) begin
                     cell_pri_in[i] = new_pri;
                     cell_pay_in[i] = new_pay;
                  end else begin
                     cell_pri_in[i] = cell_pri_ff[i-1];
                     cell_pay_in[i] = cell_pay_ff[i-1];
                  end
               end
            end
            count_in = count_ff + CW'(1);
         end
         spq_pkg::OP_REMOVE: begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               cell_pri_in[i] = cell_pri_ff[i+1];
               cell_pay_in[i] = cell_pay_ff[i+1];
            end
            count_in = count_ff - CW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_pri_ff[i] <= cell_pri_in[i];
         cell_pay_ff[i] <= cell_pay_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result register, loaded whenever a request is executed.
   always_ff @(posedge clock) begin
      if (cmd.op != spq_pkg::OP_NONE) begin
         occ_ff     <= spq_pkg::OCC_W'(count_in);
         out_pay_ff <= '0;
         out_pri_ff <= '0;
         case (cmd.op)
            spq_pkg::OP_INSERT: status_ff <= spq_pkg::STATUS_INSERTED;
            spq_pkg::OP_REMOVE: begin
               status_ff  <= spq_pkg::STATUS_REMOVED;
               out_pay_ff <= cell_pay_ff[0];
               out_pri_ff <= cell_pri_ff[0];
            end
            spq_pkg::OP_FULL:  status_ff <= spq_pkg::STATUS_FULL;
            default:           status_ff <= spq_pkg::STATUS_EMPTY;
         endcase
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_payload   = out_pay_ff;
   assign rsp_priority  = out_pri_ff;
   assign rsp_occupancy = occ_ff;

   `SPQ_NEVER(a_count_bound, count_ff > CW'(DEPTH), "entry count exceeds depth")
   `SPQ_ASSERT(a_insert_count, cmd.op == spq_pkg::OP_INSERT |=> count_ff == $past(count_ff) + CW'(1), "insert did not grow the count")
   `SPQ_ASSERT(a_full_only_when_full, cmd.op == spq_pkg::OP_FULL |-> stat.full, "insert dropped while space remained")
   `SPQ_ASSERT(a_front_order, (cmd.op == spq_pkg::OP_REMOVE && count_ff > CW'(1)) |=> out_pri_ff >= cell_pri_ff[0], "front entry not of highest priority")

endmodule

// File: rtl/sorted_priority_queue_top.sv
// Sorted priority queue holding up to DEPTH entries, each a 16-bit payload handle with a
// 4-bit priority, highest priority served first and equal priorities in arrival order.
// Requests arrive on the req_ stream: req_tuser selects insert (0) or remove (1), and
// req_tdata carries the priority and payload of an insert, which a remove ignores.
// Every request gives exactly one response on the rsp_ stream: rsp_tuser holds the status
// (inserted, removed, full with the insert dropped, or empty with nothing removed), and
// rsp_tdata holds the removed entry, zero for other outcomes, and the occupancy after it.
// The response is registered, so a request has its response valid in the cycle after it is
// accepted. Throughput is one request per cycle while responses are taken; the entries form a
// row of cells that all compare with the new priority at once and shift by one place, so each
// request settles in the cycle it is accepted, and the response register is the only stage.
// If the receiver stalls, the response is held and one more request may be accepted only
// in the cycle in which the held response is taken; otherwise req_tready stays low.
// Synchronous reset empties the queue and drops any pending response; req_tready is low
// while reset is high. Entry contents are not cleared, as only held entries are read.
module sorted_priority_queue_top #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // priority_req [3:0], payload [19:4], zero [23:20]
   input  logic [0:0]  req_tuser,   // action [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // out_payload [15:0], out_priority [19:16],
                                    // occupancy [24:20], zero [31:25]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   spq_pkg::cmd_type            cmd;
   spq_pkg::stat_type           stat;
   logic [spq_pkg::STAT_W-1:0]  rsp_status;
   logic [spq_pkg::PAY_W-1:0]   rsp_payload;
   logic [spq_pkg::PRI_W-1:0]   rsp_priority;
   logic [spq_pkg::OCC_W-1:0]   rsp_occupancy;

   // The controller decides what each accepted request does and tracks the response.
   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser[0]),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds the sorted cells, the entry count and the response register.
   spq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .new_pri       (req_tdata[3:0]),
      .new_pay       (req_tdata[19:4]),
      .stat          (stat),
      .rsp_status    (rsp_status),
      .rsp_payload   (rsp_payload),
      .rsp_priority  (rsp_priority),
      .rsp_occupancy (rsp_occupancy)
   );

   assign rsp_tdata = {7'd0, rsp_occupancy, rsp_priority, rsp_payload};
   assign rsp_tuser = rsp_status;

endmodule
